// ===== hw/rtl/gra_pkg.sv =====
// Package for the guillotine rectangle allocator.
// Payload structs, config register indexes and shared command/status types.
// No dependencies.
package gra_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATLAS_WIDTH  = 2'd0,
    CFG_ATLAS_HEIGHT = 2'd1,
    CFG_BORDER       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        restart;
    logic [15:0] tile_id;
    logic [12:0] req_w;
    logic [12:0] req_h;
  } req_t;

  typedef struct packed {
    logic [15:0] placed_id;
    logic        fits;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [12:0] span_w;
    logic [12:0] span_h;
    logic        rotated;
    logic        store_overflow;
  } rsp_t;

  typedef struct packed {
    logic reload;
    logic scan_start;
    logic split_start;
    logic merge_start;
  } dp_cmd_t;

  typedef struct packed {
    logic reload_done;
    logic scan_done;
    logic found;
    logic zero_span;
    logic split_done;
    logic merge_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/gra_datapath.sv =====
// Datapath of the guillotine rectangle allocator: free store memory, scan,
// split and merge sequencing over the store. Depends on gra_pkg.
module gra_datapath #(
  parameter int unsigned MAX_FREE  = 64,
  parameter int unsigned ATLAS_MAX = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  gra_pkg::dp_cmd_t   cmd,
  output gra_pkg::dp_sts_t   sts,
  input  gra_pkg::req_t      req,
  input  logic [12:0]        atlas_w,
  input  logic [12:0]        atlas_h,
  input  logic [7:0]         border,
  output gra_pkg::rsp_t      rsp
);

  localparam int unsigned AW = $clog2(MAX_FREE);
  localparam int unsigned CW = $clog2(MAX_FREE + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_FREE - 1);

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } rect_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLR   = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_SPL0  = 11'b00000001000,
    S_SPL1  = 11'b00000010000,
    S_MI    = 11'b00000100000,
    S_MIRD  = 11'b00001000000,
    S_MJ    = 11'b00010000000,
    S_MJRD  = 11'b00100000000,
    S_MJWB  = 11'b01000000000,
    S_MIWB  = 11'b10000000000
  } seq_t;

  rect_t mem [MAX_FREE];
  logic [MAX_FREE-1:0] vld;
  rect_t rd;
  logic [AW-1:0] ra;
  logic we;
  logic [AW-1:0] wa;
  rect_t wd;

  seq_t st;
  logic [CW-1:0] cnt;
  logic [CW-1:0] jcnt;
  logic [13:0] rw, rh;
  logic found;
  logic [AW-1:0] best;
  logic [12:0] best_key;
  logic best_rot;
  rect_t br;
  rect_t part0, part1;
  logic ovf;
  rect_t ri;
  logic ri_dirty;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

  function automatic logic [AW-1:0] first_free(input logic [MAX_FREE-1:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int k = MAX_FREE - 1; k >= 0; k--) if (!v[k]) r = AW'(k);
    return r;
  endfunction

  logic [AW-1:0] ff_idx;
  assign ff_idx = first_free(vld);

  logic [12:0] sw, sh;
  assign sw = best_rot ? rh[12:0] : rw[12:0];
  assign sh = best_rot ? rw[12:0] : rh[12:0];

  logic up, turn;
  logic [12:0] key;
  logic [AW-1:0] scan_idx;
  assign scan_idx = cnt[AW-1:0] - AW'(1);
  assign up   = rw <= rd.w && rh <= rd.h;
  assign turn = rh <= rd.w && rw <= rd.h;
  assign key  = rd.w > rd.h ? rd.w : rd.h;

  logic [12:0] cw_m, ch_m;
  assign cw_m = (atlas_w > 13'(ATLAS_MAX)) ? 13'(ATLAS_MAX) : atlas_w;
  assign ch_m = (atlas_h > 13'(ATLAS_MAX)) ? 13'(ATLAS_MAX) : atlas_h;

  logic ab_hit;
  rect_t ab_r;
  always_comb begin
    ab_hit = 1'b0;
    ab_r = ri;
    if (ri.w == rd.w && ri.x == rd.x) begin
      if (13'(ri.y) + ri.h == 13'(rd.y)) begin
        ab_hit = 1'b1; ab_r.h = ri.h + rd.h;
      end else if (13'(ri.y) == 13'(rd.y) + rd.h) begin
        ab_hit = 1'b1; ab_r.y = rd.y; ab_r.h = ri.h + rd.h;
      end
    end else if (ri.h == rd.h && ri.y == rd.y) begin
      if (13'(ri.x) + ri.w == 13'(rd.x)) begin
        ab_hit = 1'b1; ab_r.w = ri.w + rd.w;
      end else if (13'(ri.x) == 13'(rd.x) + rd.w) begin
        ab_hit = 1'b1; ab_r.x = rd.x; ab_r.w = ri.w + rd.w;
      end
    end
  end

  always_comb begin
    we = 1'b0;
    wa = cnt[AW-1:0];
    wd = ri;
    ra = cnt[AW-1:0];
    unique case (st)
      S_CLR:  begin
        we = 1'b1; wa = '0;
        wd = '{x: 12'd0, y: 12'd0, w: cw_m, h: ch_m};
      end
      S_SPL0: begin
        we = part0.w != '0 && part0.h != '0 && !(&vld); wa = ff_idx; wd = part0;
      end
      S_SPL1: begin
        we = part1.w != '0 && part1.h != '0 && !(&vld); wa = ff_idx; wd = part1;
      end
      S_MJ, S_MJRD: ra = jcnt[AW-1:0];
      S_MIWB: begin
        we = ri_dirty; wa = cnt[AW-1:0]; wd = ri;
      end
      S_SCAN: ra = cnt[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
      vld <= '0;
      cnt <= '0;
      jcnt <= '0;
      found <= 1'b0;
      ovf <= 1'b0;
      ri_dirty <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (cmd.reload) st <= S_CLR;
          else if (cmd.scan_start) begin
            st <= S_SCAN; cnt <= '0; found <= 1'b0; ovf <= 1'b0;
            rw <= {1'b0, req.req_w} + 14'(border);
            rh <= {1'b0, req.req_h} + 14'(border);
          end else if (cmd.split_start) begin
            st <= S_SPL0;
            vld[best] <= 1'b0;
            if (br.w - sw >= br.h - sh) begin
              part0 <= '{x: br.x + sw[11:0], y: br.y, w: br.w - sw, h: br.h};
              part1 <= '{x: br.x, y: br.y + sh[11:0], w: sw, h: br.h - sh};
            end else begin
              part0 <= '{x: br.x + sw[11:0], y: br.y, w: br.w - sw, h: sh};
              part1 <= '{x: br.x, y: br.y + sh[11:0], w: br.w, h: br.h - sh};
            end
          end else if (cmd.merge_start) begin
            st <= S_MI; cnt <= '0;
          end
        end
        S_CLR: begin
          vld <= '0;
          vld[0] <= cw_m != '0 && ch_m != '0;
          st <= S_IDLE;
        end
        S_SCAN: begin
          if (cnt != '0 && vld[scan_idx] && (up || turn) && (!found || key > best_key)) begin
            found <= 1'b1; best <= scan_idx; best_key <= key;
            best_rot <= !up; br <= rd;
          end
          if (cnt == CW'(MAX_FREE)) st <= S_IDLE;
          else cnt <= cnt + CW'(1);
        end
        S_SPL0: begin
          if (part0.w != '0 && part0.h != '0) begin
            if (&vld) ovf <= 1'b1; else vld[ff_idx] <= 1'b1;
          end
          st <= S_SPL1;
        end
        S_SPL1: begin
          if (part1.w != '0 && part1.h != '0) begin
            if (&vld) ovf <= 1'b1; else vld[ff_idx] <= 1'b1;
          end
          st <= S_IDLE;
        end
        S_MI: begin
          if (cnt > LAST) st <= S_IDLE;
          else if (!vld[cnt[AW-1:0]]) cnt <= cnt + CW'(1);
          else st <= S_MIRD;
        end
        S_MIRD: begin
          ri <= rd; ri_dirty <= 1'b0;
          jcnt <= cnt + CW'(1);
          st <= S_MJ;
        end
        S_MJ: begin
          if (jcnt > LAST) st <= S_MIWB;
          else if (!vld[jcnt[AW-1:0]]) jcnt <= jcnt + CW'(1);
          else st <= S_MJRD;
        end
        S_MJRD: st <= S_MJWB;
        S_MJWB: begin
          if (ab_hit) begin
            ri <= ab_r; ri_dirty <= 1'b1; vld[jcnt[AW-1:0]] <= 1'b0;
          end
          jcnt <= jcnt + CW'(1);
          st <= S_MJ;
        end
        S_MIWB: begin
          cnt <= cnt + CW'(1);
          st <= S_MI;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    sts = '0;
    sts.reload_done = st == S_CLR;
    sts.scan_done   = st == S_SCAN && cnt == CW'(MAX_FREE);
    sts.found       = found;
    sts.zero_span   = sw == '0 || sh == '0;
    sts.split_done  = st == S_SPL1;
    sts.merge_done  = st == S_MI && cnt > LAST;
  end

  always_comb begin
    rsp = '0;
    rsp.store_overflow = ovf;
    if (found) begin
      rsp.placed_id = req.tile_id;
      rsp.fits = 1'b1;
      rsp.pos_x = br.x;
      rsp.pos_y = br.y;
      rsp.span_w = sw;
      rsp.span_h = sh;
      rsp.rotated = best_rot;
    end
  end

`ifndef SYNTHESIS
  a_mj_order: assert property (@(posedge clk) disable iff (rst)
    st == S_MJWB |-> jcnt > cnt) else $error("merge j not above i");
  a_split_seq: assert property (@(posedge clk) disable iff (rst)
    st == S_SPL0 |=> st == S_SPL1) else $error("split sequence broken");
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    st == S_SCAN |-> cnt <= CW'(MAX_FREE)) else $error("scan counter overrun");
`endif

endmodule

// ===== hw/rtl/gra_ctrl.sv =====
// Request controller of the guillotine rectangle allocator.
// Sequences reload, scan, split and merge commands. Depends on gra_pkg.
module gra_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             restart,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             cap,
  output gra_pkg::dp_cmd_t cmd,
  input  gra_pkg::dp_sts_t sts
);

  typedef enum logic [8:0] {
    C_INIT   = 9'b000000001,
    C_IDLE   = 9'b000000010,
    C_RELOAD = 9'b000000100,
    C_SCAN   = 9'b000001000,
    C_SPLIT  = 9'b000010000,
    C_MERGE  = 9'b000100000,
    C_OUT    = 9'b001000000,
    C_WAIT   = 9'b010000000,
    C_PICK   = 9'b100000000
  } ctrl_t;

  ctrl_t st;
  logic rst_pend;

  assign in_ready  = st == C_IDLE;
  assign out_valid = st == C_OUT;
  assign cap       = in_valid && in_ready;

  // commands are issued when the datapath sits idle; merge_start stays asserted through the merge pass
  always_comb begin
    cmd = '0;
    unique case (st)
      C_IDLE:   cmd.reload = cap && restart;
      C_WAIT:   cmd.scan_start = 1'b1;
      C_PICK:   cmd.split_start = sts.found && !sts.zero_span;
      C_MERGE:  cmd.merge_start = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= C_INIT;
      rst_pend <= 1'b0;
    end else begin
      unique case (st)
        C_INIT:   if (sts.reload_done) st <= C_IDLE;
        C_IDLE:   if (cap) begin
          rst_pend <= restart;
          st <= restart ? C_RELOAD : C_WAIT;
        end
        C_RELOAD: if (sts.reload_done) st <= C_WAIT;
        C_WAIT:   st <= C_SCAN;
        C_SCAN:   if (sts.scan_done) st <= C_PICK;
        C_PICK:   st <= (sts.found && !sts.zero_span) ? C_SPLIT : C_OUT;
        C_SPLIT:  if (sts.split_done) st <= C_MERGE;
        C_MERGE:  if (sts.merge_done) st <= C_OUT;
        C_OUT:    if (out_ready) st <= C_IDLE;
        default:  st <= C_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rst_flag: assert property (@(posedge clk) disable iff (rst)
    st == C_RELOAD |-> rst_pend) else $error("reload without restart");
`endif

endmodule

// ===== hw/rtl/guillotine_rect_allocator_core.sv =====
// Top level of the guillotine rectangle allocator.
// Channel   | handshake          | payload
// in        | in_valid/in_ready  | in  (gra_pkg::req_t)
// out       | out_valid/out_ready| out (gra_pkg::rsp_t)
// cfg       | cfg_we             | cfg_idx, cfg_data
// One request at a time: scan and split (after a store reload on restart),
// then a merge pass over the store, paced by the single store read port.
// No fit or zero span skips split and merge.
// Reset and restart reload the store; no request taken meanwhile.
// The result holds until out_ready; no new request is taken until then.
module guillotine_rect_allocator_core #(
  parameter int unsigned MAX_FREE  = 64,
  parameter int unsigned ATLAS_MAX = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gra_pkg::req_t                     in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gra_pkg::rsp_t                     out,
  input  logic                              cfg_we,
  input  logic [gra_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [gra_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [12:0] atlas_w, atlas_h;
  logic [7:0] border;
  gra_pkg::req_t req;
  gra_pkg::dp_cmd_t cmd;
  gra_pkg::dp_sts_t sts;
  logic cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_w <= 13'd1024;
      atlas_h <= 13'd1024;
      border <= 8'd0;
    end else if (cfg_we) begin
      priority case (cfg_idx)
        gra_pkg::CFG_ATLAS_WIDTH:  atlas_w <= cfg_data;
        gra_pkg::CFG_ATLAS_HEIGHT: atlas_h <= cfg_data;
        gra_pkg::CFG_BORDER:       border <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) if (cap) req <= in;

  gra_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .restart(in.restart),
    .out_valid, .out_ready, .cap, .cmd, .sts
  );

  gra_datapath #(.MAX_FREE(MAX_FREE), .ATLAS_MAX(ATLAS_MAX)) u_dp (
    .clk, .rst, .cmd, .sts, .req, .atlas_w, .atlas_h, .border, .rsp(out)
  );

endmodule

// ===== tb/sv/gra_checker.sv =====
// Scoreboard for the guillotine rectangle allocator: watches config writes and both
// channels, predicts each result from its own copy of the free store, and compares.
// Depends on gra_pkg.
module gra_checker #(
  parameter int unsigned MAX_FREE  = 64,
  parameter int unsigned ATLAS_MAX = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  gra_pkg::req_t                  in,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  gra_pkg::rsp_t                  out,
  input  logic                           cfg_we,
  input  logic [gra_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gra_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             placed_cnt,
  output int                             rot_cnt,
  output int                             ovf_cnt,
  output int                             miss_cnt
);

  int unsigned atlas_w, atlas_h, pad;
  int unsigned fx[MAX_FREE], fy[MAX_FREE], fw[MAX_FREE], fh[MAX_FREE];
  bit          fv[MAX_FREE];
  gra_pkg::rsp_t placements[$];

  assign pending = placements.size();

  function automatic void reload_atlas();
    int unsigned w, h;
    w = (atlas_w > ATLAS_MAX) ? ATLAS_MAX : atlas_w;
    h = (atlas_h > ATLAS_MAX) ? ATLAS_MAX : atlas_h;
    for (int i = 0; i < MAX_FREE; i++) begin
      fx[i] = 0; fy[i] = 0; fw[i] = 0; fh[i] = 0; fv[i] = 0;
    end
    if (w > 0 && h > 0) begin
      fw[0] = w; fh[0] = h; fv[0] = 1;
    end
  endfunction

  function automatic bit store_rect(int unsigned x, int unsigned y,
                                    int unsigned w, int unsigned h);
    if (w == 0 || h == 0) return 1;
    for (int i = 0; i < MAX_FREE; i++) begin
      if (!fv[i]) begin
        fx[i] = x; fy[i] = y; fw[i] = w; fh[i] = h; fv[i] = 1;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit join_rects(int a, int b);
    if (fw[a] == fw[b] && fx[a] == fx[b]) begin
      if (fy[a] + fh[a] == fy[b]) begin
        fh[a] += fh[b]; return 1;
      end
      if (fy[a] == fy[b] + fh[b]) begin
        fy[a] = fy[b]; fh[a] += fh[b]; return 1;
      end
    end else if (fh[a] == fh[b] && fy[a] == fy[b]) begin
      if (fx[a] + fw[a] == fx[b]) begin
        fw[a] += fw[b]; return 1;
      end
      if (fx[a] == fx[b] + fw[b]) begin
        fx[a] = fx[b]; fw[a] += fw[b]; return 1;
      end
    end
    return 0;
  endfunction

  function automatic gra_pkg::rsp_t place_tile(gra_pkg::req_t r);
    gra_pkg::rsp_t e;
    int unsigned rw, rh, key, best_key, sw, sh, x, y, w, h;
    int          best;
    bit          up, turn, rot, ok1, ok2;
    rw = int'(r.req_w) + pad;
    rh = int'(r.req_h) + pad;
    best = -1; best_key = 0; rot = 0;
    e = '0;
    if (r.restart) reload_atlas();
    for (int i = 0; i < MAX_FREE; i++) begin
      if (!fv[i]) continue;
      up   = rw <= fw[i] && rh <= fh[i];
      turn = rh <= fw[i] && rw <= fh[i];
      if (!up && !turn) continue;
      key = (fw[i] > fh[i]) ? fw[i] : fh[i];
      if (best < 0 || key > best_key) begin
        best = i; best_key = key; rot = !up;
      end
    end
    if (best >= 0) begin
      sw = rot ? rh : rw;
      sh = rot ? rw : rh;
      x = fx[best]; y = fy[best]; w = fw[best]; h = fh[best];
      e.placed_id = r.tile_id;
      e.fits      = 1;
      e.pos_x     = x[11:0];
      e.pos_y     = y[11:0];
      e.span_w    = sw[12:0];
      e.span_h    = sh[12:0];
      e.rotated   = rot;
      if (sw > 0 && sh > 0) begin
        fv[best] = 0;
        if (w - sw >= h - sh) begin
          ok1 = store_rect(x + sw, y, w - sw, h);
          ok2 = store_rect(x, y + sh, sw, h - sh);
        end else begin
          ok1 = store_rect(x + sw, y, w - sw, sh);
          ok2 = store_rect(x, y + sh, w, h - sh);
        end
        e.store_overflow = !ok1 || !ok2;
        for (int i = 0; i < MAX_FREE; i++) begin
          if (!fv[i]) continue;
          for (int j = i + 1; j < MAX_FREE; j++)
            if (fv[j] && join_rects(i, j)) fv[j] = 0;
        end
      end
    end
    return e;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    gra_pkg::rsp_t e;
    if (rst) begin
      errors = 0; placed_cnt = 0; rot_cnt = 0; ovf_cnt = 0; miss_cnt = 0;
      atlas_w = 1024; atlas_h = 1024; pad = 0;
      reload_atlas();
      placements.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (placements.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          e = placements.pop_front();
          check_field("placed_id", e.placed_id, out.placed_id);
          check_field("fits", e.fits, out.fits);
          check_field("pos_x", e.pos_x, out.pos_x);
          check_field("pos_y", e.pos_y, out.pos_y);
          check_field("span_w", e.span_w, out.span_w);
          check_field("span_h", e.span_h, out.span_h);
          check_field("rotated", e.rotated, out.rotated);
          check_field("store_overflow", e.store_overflow, out.store_overflow);
          if (e.fits) placed_cnt++; else miss_cnt++;
          if (e.rotated) rot_cnt++;
          if (e.store_overflow) ovf_cnt++;
        end
      end
      if (in_valid && in_ready) placements = {placements, place_tile(in)};
      if (cfg_we) begin
        unique case (gra_pkg::cfg_idx_t'(cfg_idx))
          gra_pkg::CFG_ATLAS_WIDTH:  atlas_w = cfg_data;
          gra_pkg::CFG_ATLAS_HEIGHT: atlas_h = cfg_data;
          gra_pkg::CFG_BORDER:       pad = cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the allocator testbench: clock, reset, request and config stimulus with
// bursty sending and patterned result stalls; verdict from gra_checker's count.
// Depends on gra_pkg, gra_checker and guillotine_rect_allocator_core.
module testbench;

  localparam longint LIMIT = 30_000_000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_valid, in_ready, out_ready = 0;
  gra_pkg::req_t in = '0;
  gra_pkg::rsp_t out;
  logic cfg_we = 0;
  logic [gra_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [gra_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int errors, pending, placed_cnt, rot_cnt, ovf_cnt, miss_cnt;
  longint cycles = 0;
  int burst_left = 0;
  int unsigned cur_w = 1024, cur_h = 1024;
  int sent = 0;

  always #1 clk = ~clk;

  guillotine_rect_allocator_core dut (
    .clk, .rst, .in_valid, .in_ready, .in, .out_valid, .out_ready, .out,
    .cfg_we, .cfg_idx, .cfg_data
  );

  gra_checker chk (
    .clk, .rst, .in_valid, .in_ready, .in, .out_valid, .out_ready, .out,
    .cfg_we, .cfg_idx, .cfg_data, .errors, .pending, .placed_cnt, .rot_cnt,
    .ovf_cnt, .miss_cnt
  );

  // result stall pattern: rotates among always ready, random, mostly stalled and periodic out_ready
  always @(posedge clk) begin
    cycles <= cycles + 1;
    case ((cycles >> 8) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(1, 0) == 1);
      2: out_ready <= ($urandom_range(3, 0) == 0);
      default: out_ready <= cycles[2];
    endcase
    if (cycles > LIMIT) begin
      $display("guillotine_rect_allocator_core: mismatch");
      $finish;
    end
  end

  task automatic send_beat(bit rs, logic [15:0] id, logic [12:0] w, logic [12:0] h);
    in_valid <= 1'b1;
    in <= '{restart: rs, tile_id: id, req_w: w, req_h: h};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = $urandom_range(3) == 0 ? 0 : $urandom_range(8, 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(gra_pkg::cfg_idx_t idx, logic [gra_pkg::CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic set_atlas(int unsigned w, int unsigned h, int unsigned b);
    drain();
    write_reg(gra_pkg::CFG_ATLAS_WIDTH, w[12:0]);
    write_reg(gra_pkg::CFG_ATLAS_HEIGHT, h[12:0]);
    write_reg(gra_pkg::CFG_BORDER, b[12:0]);
    cfg_we <= 1'b0;
    cur_w = w; cur_h = h;
  endtask

  function automatic logic [12:0] pick_size(int unsigned span);
    int unsigned r, top;
    r = $urandom_range(99);
    top = span / 8 > 1 ? span / 8 : 1;
    if (top > 8191) top = 8191;
    if (r < 75) return 13'($urandom_range(top, 1));
    if (r < 92) return 13'($urandom_range(span > 8191 ? 8191 : (span > 0 ? span : 1), 1));
    if (r < 94) return 13'd0;
    return 13'($urandom());
  endfunction

  task automatic random_phase(int n);
    int seq_left;
    seq_left = 0;
    for (int k = 0; k < n; k++) begin
      bit rs;
      rs = 0;
      if (seq_left == 0) begin
        rs = 1;
        seq_left = $urandom_range(3) == 0 ? $urandom_range(120, 60) : $urandom_range(40, 3);
      end else if ($urandom_range(49) == 0) begin
        rs = 1;
      end
      seq_left--;
      send_beat(rs, 16'($urandom()), pick_size(cur_w), pick_size(cur_h));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero span, tile id zero, whole atlas, no fit, rotation, oversize
    send_beat(1'b0, 16'd0, 13'd0, 13'd0);
    send_beat(1'b0, 16'hFFFF, 13'd1024, 13'd1024);
    send_beat(1'b0, 16'd5, 13'd1, 13'd1);
    send_beat(1'b1, 16'd6, 13'd100, 13'd1024);
    send_beat(1'b0, 16'd7, 13'd1000, 13'd500);
    send_beat(1'b1, 16'd8, 13'h1FFF, 13'h1FFF);
    send_beat(1'b1, 16'd9, 13'd4096, 13'd1);
    send_beat(1'b0, 16'd0, 13'd3, 13'd5);
    set_atlas(8191, 8191, 255);
    send_beat(1'b0, 16'd10, 13'd1, 13'd1);
    send_beat(1'b1, 16'd11, 13'd3841, 13'd100);
    send_beat(1'b0, 16'd12, 13'd0, 13'd0);
    send_beat(1'b0, 16'd13, 13'h1FFF, 13'd1);
    set_atlas(0, 100, 0);
    send_beat(1'b1, 16'd14, 13'd1, 13'd1);
    set_atlas(1, 1, 0);
    send_beat(1'b1, 16'd15, 13'd1, 13'd1);
    send_beat(1'b0, 16'd16, 13'd1, 13'd1);
    send_beat(1'b0, 16'd17, 13'd0, 13'd0);

    set_atlas(1024, 1024, 0);   random_phase(120);
    set_atlas(4096, 4096, 255); random_phase(60);
    set_atlas(300, 200, 3);     random_phase(90);
    set_atlas(2048, 512, 1);    random_phase(90);
    set_atlas(8191, 16, 0);     random_phase(40);
    set_atlas(1, 4096, 0);      random_phase(30);
    set_atlas($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(255));
    random_phase(100);
    set_atlas(512, 512, 0);     random_phase(110);

    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests over twelve atlas settings: %0d placed, %0d rejected,",
             sent, placed_cnt, miss_cnt);
    $display("%0d placed turned, %0d with free store overflow.", rot_cnt, ovf_cnt);
    if (errors == 0)
      $display("guillotine_rect_allocator_core: match");
    else
      $display("guillotine_rect_allocator_core: mismatch");
    $finish;
  end
endmodule
